>>> hdl/pit_pkg.sv
`timescale 1ns / 1ps

package pit_pkg;

  localparam int unsigned KIND_W        = 2;
  localparam int unsigned CHAN_W        = 2;
  localparam int unsigned SEL_W         = 3;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned IRQ_W         = 4;
  // Channels that the channel field can reach and that drive irq_lines
  localparam int unsigned ADDR_CHANNELS = 4;

  // Bit positions inside the register words
  localparam int unsigned CTRL_EN_BIT  = 0;
  localparam int unsigned CTRL_IEN_BIT = 1;
  localparam int unsigned FLAG_BIT     = 0;
  localparam int unsigned MOD_FRZ_BIT  = 0;
  localparam int unsigned MOD_DIS_BIT  = 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } pit_kind_e;

  typedef enum logic [SEL_W-1:0] {
    REG_LOAD   = 3'd0,
    REG_COUNT  = 3'd1,
    REG_CTRL   = 3'd2,
    REG_FLAG   = 3'd3,
    REG_MODULE = 3'd4
  } pit_reg_e;

  // Per-channel command for one request
  typedef struct packed {
    logic              tick;
    logic              wr_load;
    logic              wr_ctrl;
    logic              wr_flag;
    logic [DATA_W-1:0] data;
  } pit_chan_cmd_t;

  // Per-channel register view
  typedef struct packed {
    logic [DATA_W-1:0] load;
    logic [DATA_W-1:0] count;
    logic              run;
    logic              ien;
    logic              flag;
  } pit_chan_st_t;

endpackage

>>> hdl/pit_req_if.sv
`timescale 1ns / 1ps

interface pit_req_if import pit_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAN_W-1:0] channel;
  logic [SEL_W-1:0]  reg_select;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, kind, channel, reg_select, write_data, input ready);
  modport sink   (input valid, kind, channel, reg_select, write_data, output ready);
endinterface

>>> hdl/pit_rsp_if.sv
`timescale 1ns / 1ps

interface pit_rsp_if import pit_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [IRQ_W-1:0]  irq_lines;

  modport source (output valid, read_data, irq_lines, input ready);
  modport sink   (input valid, read_data, irq_lines, output ready);
endinterface

>>> hdl/periodic_interrupt_timer.sv
`timescale 1ns / 1ps

// Periodic interrupt timer with CHANNELS down-counters behind a register port.
// Requests arrive on req_i (valid/ready): kind selects a tick, a register read
// or a register write; channel, reg_select and write_data address the register.
// Every request yields exactly one response on rsp_o carrying read_data (zero
// unless the request was a read) and irq_lines, the per-channel flag AND
// interrupt enable as they stand after that request has been applied.
// A tick drives the time base: while the module is not disabled, each enabled
// channel counts down, and a channel at zero sets its flag and reloads, so one
// period is load value plus one ticks.
// A request is held in the input register and applied to the channel state as
// its response enters the result register. Throughput: one request per cycle
// unless stalled, set by the single input register feeding the result register.
// Reset clears all channel registers and the freeze bit and sets the module
// disable bit; both pipeline registers come up empty.
// When the receiver stalls, the response register holds; the input register
// still takes one more request, then ready drops until the response is taken.
module periodic_interrupt_timer import pit_pkg::*; #(
  parameter int CHANNELS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pit_req_if.sink   req_i,
  pit_rsp_if.source rsp_o
);

  // Input register
  logic              s1_valid_q, s1_valid_d;
  logic [KIND_W-1:0] s1_kind_q;
  logic [CHAN_W-1:0] s1_chan_q;
  logic [SEL_W-1:0]  s1_sel_q;
  logic [DATA_W-1:0] s1_data_q;

  // Result register
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] rdata_q, rdata_d;
  logic [IRQ_W-1:0]  irq_q, irq_d;

  // Module control
  logic dis_q, dis_d;
  logic frz_q, frz_d;

  logic advance;
  logic fire;
  logic req_fire;
  logic is_tick, is_read, is_write;
  logic ch_ok;

  pit_chan_cmd_t                    cmd   [CHANNELS];
  pit_chan_st_t                     st    [CHANNELS];
  logic          [CHANNELS-1:0]     irq_nx;
  logic          [CHANNELS-1:0][DATA_W-1:0] count_vec;
  pit_chan_st_t                     st_rd [ADDR_CHANNELS];
  logic          [IRQ_W-1:0]        irq_now;

  // Move the held request on whenever the result register is free or drained
  assign advance     = !out_valid_q || rsp_o.ready;
  assign fire        = s1_valid_q && advance;
  assign req_i.ready = !s1_valid_q || advance;
  assign req_fire    = req_i.valid && req_i.ready;

  assign is_tick  = (s1_kind_q == KIND_TICK);
  assign is_read  = (s1_kind_q == KIND_READ);
  assign is_write = (s1_kind_q == KIND_WRITE);
  assign ch_ok    = (32'(s1_chan_q) < CHANNELS);

  // Channel bank
  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic sel_here;
    if (c < ADDR_CHANNELS) begin : g_addr
      assign sel_here = ch_ok && (s1_chan_q == CHAN_W'(c));
    end else begin : g_noaddr
      // upper channels count but cannot be addressed
      assign sel_here = 1'b0;
    end

    assign cmd[c].tick    = fire && is_tick && !dis_q;
    assign cmd[c].wr_load = fire && is_write && sel_here && (s1_sel_q == REG_LOAD);
    assign cmd[c].wr_ctrl = fire && is_write && sel_here && (s1_sel_q == REG_CTRL);
    assign cmd[c].wr_flag = fire && is_write && sel_here && (s1_sel_q == REG_FLAG);
    assign cmd[c].data    = s1_data_q;

    pit_chan u_chan (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd[c]),
      .st_o    (st[c]),
      .irq_d_o (irq_nx[c])
    );

    assign count_vec[c] = st[c].count;
  end

  // Pad the addressable view to the full channel field
  for (genvar a = 0; a < ADDR_CHANNELS; a++) begin : g_view
    if (a < CHANNELS) begin : g_real
      assign st_rd[a]   = st[a];
      assign irq_d[a]   = irq_nx[a];
      assign irq_now[a] = st[a].flag & st[a].ien;
    end else begin : g_pad
      assign st_rd[a]   = '0;
      assign irq_d[a]   = 1'b0;
      assign irq_now[a] = 1'b0;
    end
  end

  // Module register write ignores the channel field
  always_comb begin
    dis_d = dis_q;
    frz_d = frz_q;
    if (fire && is_write && (s1_sel_q == REG_MODULE)) begin
      dis_d = s1_data_q[MOD_DIS_BIT];
      frz_d = s1_data_q[MOD_FRZ_BIT];
    end
  end

  // Read decode; out-of-range selectors and channels read as zero
  always_comb begin
    rdata_d = '0;
    if (is_read) begin
      unique case (s1_sel_q)
        REG_MODULE: begin
          rdata_d[MOD_DIS_BIT] = dis_q;
          rdata_d[MOD_FRZ_BIT] = frz_q;
        end
        REG_LOAD: begin
          if (ch_ok) rdata_d = st_rd[s1_chan_q].load;
        end
        REG_COUNT: begin
          if (ch_ok) rdata_d = st_rd[s1_chan_q].count;
        end
        REG_CTRL: begin
          if (ch_ok) begin
            rdata_d[CTRL_EN_BIT]  = st_rd[s1_chan_q].run;
            rdata_d[CTRL_IEN_BIT] = st_rd[s1_chan_q].ien;
          end
        end
        REG_FLAG: begin
          if (ch_ok) rdata_d[FLAG_BIT] = st_rd[s1_chan_q].flag;
        end
        default: rdata_d = '0;
      endcase
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (req_fire) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = advance ? s1_valid_q : out_valid_q;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      dis_q       <= 1'b1;
      frz_q       <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      dis_q       <= dis_d;
      frz_q       <= frz_d;
    end
  end

  // Payload: capture on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_kind_q <= req_i.kind;
      s1_chan_q <= req_i.channel;
      s1_sel_q  <= req_i.reg_select;
      s1_data_q <= req_i.write_data;
    end
    if (fire) begin
      rdata_q <= rdata_d;
      irq_q   <= irq_d;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = rdata_q;
  assign rsp_o.irq_lines = irq_q;

`ifndef SYNTHESIS
  // A pending response always mirrors the live interrupt state
  a_irq_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (irq_q == irq_now))
    else $error("irq_lines out of step with channel state");

  // Ticks while disabled leave every counter alone
  a_dis_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && is_tick && dis_q) |=> $stable(count_vec))
    else $error("counter moved while module disabled");

  // Only reads return data
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !is_read) |=> (rdata_q == '0))
    else $error("non-read request returned data");
`endif

endmodule

>>> hdl/pit_chan.sv
`timescale 1ns / 1ps

module pit_chan import pit_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pit_chan_cmd_t cmd_i,
  output pit_chan_st_t  st_o,
  output logic          irq_d_o
);

  logic [DATA_W-1:0] load_q, load_d;
  logic [DATA_W-1:0] count_q, count_d;
  logic              run_q, run_d;
  logic              ien_q, ien_d;
  logic              flag_q, flag_d;

  always_comb begin
    load_d  = load_q;
    count_d = count_q;
    run_d   = run_q;
    ien_d   = ien_q;
    flag_d  = flag_q;
    // expire and reload on zero, otherwise count down
    if (cmd_i.tick && run_q) begin
      if (count_q == '0) begin
        flag_d  = 1'b1;
        count_d = load_q;
      end else begin
        count_d = count_q - DATA_W'(1);
      end
    end
    if (cmd_i.wr_load) begin
      load_d = cmd_i.data;
    end
    if (cmd_i.wr_ctrl) begin
      // restart only on a rising enable
      if (cmd_i.data[CTRL_EN_BIT] && !run_q) begin
        count_d = load_q;
      end
      run_d = cmd_i.data[CTRL_EN_BIT];
      ien_d = cmd_i.data[CTRL_IEN_BIT];
    end
    if (cmd_i.wr_flag && cmd_i.data[FLAG_BIT]) begin
      flag_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q  <= '0;
      count_q <= '0;
      run_q   <= 1'b0;
      ien_q   <= 1'b0;
      flag_q  <= 1'b0;
    end else begin
      load_q  <= load_d;
      count_q <= count_d;
      run_q   <= run_d;
      ien_q   <= ien_d;
      flag_q  <= flag_d;
    end
  end

  assign st_o.load  = load_q;
  assign st_o.count = count_q;
  assign st_o.run   = run_q;
  assign st_o.ien   = ien_q;
  assign st_o.flag  = flag_q;
  assign irq_d_o    = flag_d & ien_d;

endmodule
